@@ rtl/nearest_grid_index_search_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest grid index search block
// Concurrent checks on a rising clock; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_GRID_INDEX_SEARCH_MACROS_SVH
`define NEAREST_GRID_INDEX_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define NGIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define NGIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NGIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define NGIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/ngis_pkg.sv @@
// ----------------------------------------------------------------------------
// ngis_pkg
// Types and fixed constants of the nearest grid index search block.
// ----------------------------------------------------------------------------
package ngis_pkg;

    localparam int COORD_W   = 26;
    localparam int GRID_W    = 8;
    localparam int ENTRY_W   = 8;
    localparam int CNT_REG_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam int LAT_LIMIT_DEG = 90;
    localparam int LON_LIMIT_DEG = 360;

    localparam logic [CFG_IDX_W-1:0] CFG_LAT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_COUNT = 2'd1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic AXIS_LAT = 1'b0;
    localparam logic AXIS_LON = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_LOW   = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_DIFF  = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_RES   = 7'b1000000
    } t_state;

endpackage

@@ rtl/nearest_grid_index_search.sv @@
// ----------------------------------------------------------------------------
// nearest_grid_index_search
// Nearest-entry search over ascending latitude and longitude tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (i_valid / o_stall) are either loads or queries. A load
//   writes one entry of the table chosen by i_axis in the cycle it is taken;
//   loads can follow each other every cycle while no query runs and produce
//   no result. A query produces one result (o_valid / i_stall) carrying
//   o_grid_index and o_invalid.
//   Config writes (i_cfg_valid, always ready) set lat_count (index 0) and
//   lon_count (index 1); other indexes are dropped.
//   Query sequence: a rejected query (empty table or out of range) goes
//   from idle straight to the result state and then the output register;
//   otherwise it passes the first-read, low, walk, difference, compare and
//   result states. The walk reads one table entry per cycle through the
//   RAM read port and one compare unit. The block stalls its input for the
//   whole query; the result sits in an output register, so a new request
//   is taken while it waits. A query can only leave the sequencer once
//   that register is free.
//   Reset clears both counts and the control state; table contents persist
//   and are undefined until loaded.
// ----------------------------------------------------------------------------
`include "nearest_grid_index_search_macros.svh"

module nearest_grid_index_search
    import ngis_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic                      i_axis,
    input  logic [ENTRY_W-1:0]        i_entry_index,
    input  logic signed [COORD_W-1:0] i_coord_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [GRID_W-1:0]         o_grid_index,
    output logic                      o_invalid,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CNT_REG_W-1:0]      i_cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
    localparam int AW    = (FRAC_BITS + 11 > 28) ? FRAC_BITS + 11 : 28;

    localparam logic signed [AW-1:0] LAT_MAX = AW'(LAT_LIMIT_DEG) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] LAT_MIN = -LAT_MAX;
    localparam logic signed [AW-1:0] LON_MAX = AW'(LON_LIMIT_DEG) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] LON_MIN = '0;

    t_state                  r_state;
    logic [CNT_REG_W-1:0]    r_lat_count;
    logic [CNT_REG_W-1:0]    r_lon_count;
    logic                    r_axis;
    logic signed [AW-1:0]    r_q;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_idx;
    logic signed [AW-1:0]    r_low;
    logic signed [AW-1:0]    r_high;
    logic signed [AW-1:0]    r_dlow;
    logic signed [AW-1:0]    r_dhigh;
    logic [CNT_W-1:0]        r_res_idx;
    logic                    r_res_inv;
    logic                    r_out_valid;
    logic [GRID_W-1:0]       r_out_idx;
    logic                    r_out_inv;

    logic                    in_take;
    logic                    out_free;
    logic                    q_bad;
    logic signed [AW-1:0]    q_ext;
    logic [CW-1:0]           cnt_raw;
    logic [CNT_W-1:0]        cnt_eff;
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        idx_dec;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_ok;
    logic                    wr_lat;
    logic                    wr_lon;
    logic [COORD_W-1:0]      lat_rd;
    logic [COORD_W-1:0]      lon_rd;
    logic signed [AW-1:0]    rd_ext;
    logic                    walk_more;
    logic                    at_end;
    logic [AW-1:0]           mag_low;
    logic [AW-1:0]           mag_high;
    logic [AW-1:0]           deg_low;
    logic [AW-1:0]           deg_high;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // Table writes
    assign wr_ok  = int'(i_entry_index) < TABLE_DEPTH;
    assign wr_lat = in_take && (i_action == ACT_LOAD) && (i_axis == AXIS_LAT) && wr_ok;
    assign wr_lon = in_take && (i_action == ACT_LOAD) && (i_axis == AXIS_LON) && wr_ok;

    assign idx_inc = r_idx + CNT_W'(1);
    assign idx_dec = r_idx - CNT_W'(1);
    assign rd_addr = (r_state == S_FIRST) ? r_idx[IDX_W-1:0] : idx_inc[IDX_W-1:0];

    ngis_ram #(.WIDTH(COORD_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_lat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_lat),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data (i_coord_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (lat_rd)
    );

    ngis_ram #(.WIDTH(COORD_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_lon_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_lon),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data (i_coord_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (lon_rd)
    );

    // Query admission: saturated count and range check
    always_comb begin
        q_ext   = AW'(i_coord_value);
        cnt_raw = (i_axis == AXIS_LAT) ? CW'(r_lat_count) : CW'(r_lon_count);
        cnt_eff = (cnt_raw > CW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_raw);
        if (i_axis == AXIS_LAT) begin
            q_bad = (q_ext < LAT_MIN) || (q_ext > LAT_MAX);
        end else begin
            q_bad = (q_ext < LON_MIN) || (q_ext > LON_MAX);
        end
        q_bad = q_bad || (cnt_eff == '0);
    end

    assign rd_ext    = (r_axis == AXIS_LAT) ? AW'($signed(lat_rd)) : AW'($signed(lon_rd));
    assign at_end    = (r_idx == r_n);
    assign walk_more = !at_end && (rd_ext < r_q);

    // Whole-degree distances
    assign mag_low  = r_dlow[AW-1] ? AW'(-r_dlow) : AW'(r_dlow);
    assign mag_high = r_dhigh[AW-1] ? AW'(-r_dhigh) : AW'(r_dhigh);
    assign deg_low  = mag_low >> FRAC_BITS;
    assign deg_high = mag_high >> FRAC_BITS;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_count <= '0;
            r_lon_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LAT_COUNT: r_lat_count <= i_cfg_data;
                CFG_LON_COUNT: r_lon_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take && (i_action == ACT_QUERY)) begin
                        r_state <= q_bad ? S_RES : S_FIRST;
                    end
                end
                S_FIRST: r_state <= S_LOW;
                S_LOW:   r_state <= S_WALK;
                S_WALK: begin
                    if (!walk_more) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF:  r_state <= S_CMP;
                S_CMP:   r_state <= S_RES;
                S_RES: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_axis    <= i_axis;
                r_q       <= q_ext;
                r_n       <= cnt_eff;
                r_idx     <= '0;
                r_res_idx <= '0;
                r_res_inv <= q_bad;
            end
            S_LOW: begin
                r_low <= rd_ext;
                r_idx <= CNT_W'(1);
            end
            S_WALK: begin
                if (walk_more) begin
                    r_low <= rd_ext;
                    r_idx <= idx_inc;
                end else begin
                    r_high <= at_end ? LON_MAX : rd_ext;
                end
            end
            S_DIFF: begin
                r_dlow  <= r_q - r_low;
                r_dhigh <= r_high - r_q;
            end
            S_CMP: begin
                // latitude past the end always keeps the last index
                if ((deg_low > deg_high) && !(at_end && (r_axis == AXIS_LAT))) begin
                    r_res_idx <= at_end ? '0 : r_idx;
                end else begin
                    r_res_idx <= idx_dec;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RES) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RES) && out_free) begin
            r_out_idx <= GRID_W'(r_res_idx);
            r_out_inv <= r_res_inv;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_grid_index = r_out_idx;
    assign o_invalid    = r_out_inv;

    `NGIS_ASSERT_NOW(a_walk_bound, i_clk, i_rst_n, (r_state == S_WALK), (r_idx <= r_n),
        "walk index past count")
    `NGIS_ASSERT_NEXT(a_query_start, i_clk, i_rst_n, (in_take && (i_action == ACT_QUERY)),
        ((r_state == S_FIRST) || (r_state == S_RES)), "query did not start")
    `NGIS_ASSERT_NOW(a_res_range, i_clk, i_rst_n, ((r_state == S_RES) && !r_res_inv),
        (r_res_idx < r_n), "result index out of table")
    `NGIS_ASSERT_NEXT(a_out_source, i_clk, i_rst_n, (!r_out_valid && (r_state != S_RES)),
        !r_out_valid, "result without query")

endmodule

@@ rtl/ngis_ram.sv @@
// ----------------------------------------------------------------------------
// ngis_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ngis_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
